/* sv/lrs_pkg.sv */
package lrs_pkg;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // Smallest grid side, border included
  localparam logic [CFG_DATA_W-1:0] GRID_MIN  = 11'd3;
  localparam int                    GRID_RST  = 1024;

  // Life rule neighbor counts
  localparam logic [3:0] BIRTH_CNT = 4'd3;
  localparam logic [3:0] KEEP_CNT  = 4'd2;

  // One window column: bit 0 top row, bit 2 newest row
  typedef logic [2:0] win_col_t;

  // Saturate a grid side to [3, hi]
  function automatic logic [CFG_DATA_W-1:0] clamp_size(
    input logic [CFG_DATA_W-1:0] v,
    input int                    hi
  );
    logic [CFG_DATA_W-1:0] res;
    res = v;
    if (v < GRID_MIN) begin
      res = GRID_MIN;
    end else if (32'(v) > 32'(hi)) begin
      res = CFG_DATA_W'(hi);
    end
    return res;
  endfunction

  // Next state of one cell from its state and its live neighbor count
  function automatic logic life_next(input logic centre, input logic [3:0] sum);
    logic res;
    if (centre) begin
      res = (sum == KEEP_CNT) || (sum == BIRTH_CNT);
    end else begin
      res = (sum == BIRTH_CNT);
    end
    return res;
  endfunction

endpackage

/* sv/lrs_ram.sv */
module lrs_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, hold data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/lrs_cell.sv */
module lrs_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              shift_en,
  input  lrs_pkg::win_col_t col_in,
  output lrs_pkg::win_col_t col_out,
  output logic [1:0]        edge_live
);
  import lrs_pkg::*;

  win_col_t col_r;

  // Take the neighbor's column on each shift
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (shift_en) begin
      col_r <= col_in;
    end
  end

  assign col_out   = col_r;
  // Live count of the top and bottom rows of this column
  assign edge_live = {1'b0, col_r[0]} + {1'b0, col_r[2]};

endmodule

/* sv/life_rule_stencil_3x3_core.sv */
// One generation of Conway's Life over a frame streamed in raster order, one
// cell per transaction, border rows and columns included. The block takes one
// cell per clock unless the output stalls; a result is registered after the
// cell that completes its neighborhood (the cell below-right of it), and only
// interior cells give a result, the last one flagged by out_last_cell. The
// two line stores share one RAM of MAX_WIDTH x 2 bits, read and written at
// most once per clock; a fill mark makes never-written entries read as zero,
// so no clearing pass follows reset. A size write restarts the frame at row
// 0, column 0; sizes are saturated to [3, MAX_WIDTH] and [3, MAX_HEIGHT].
module life_rule_stencil_3x3_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_cell_in,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_cell_out,
  output logic                           out_last_cell,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [lrs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lrs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lrs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);
  localparam int HW = $clog2(MAX_WIDTH + 1);
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST  = clamp_size(CFG_DATA_W'(GRID_RST), MAX_WIDTH);
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RST = clamp_size(CFG_DATA_W'(GRID_RST), MAX_HEIGHT);

  logic [CFG_DATA_W-1:0] grid_w_r, grid_h_r;
  logic [CW-1:0]         col_r, col_nxt;
  logic [RW-1:0]         row_r, row_nxt;
  logic [HW-1:0]         fill_r, fill_nxt;

  logic          in_fire, cfg_fire, col_wrap, row_wrap;
  logic          s1_go, s2_go;
  logic          s1_v_r, s1_bit_r, s1_fresh_r, s1_emit_r, s1_last_r;
  logic [CW-1:0] s1_addr_r;
  logic          s2_v_r, s2_emit_r, s2_last_r;
  logic          out_valid_r, out_cell_r, out_last_r;
  logic [1:0]    rdata;
  logic          top_bit, mid_bit;
  win_col_t      new_col, col0, col1, col2;
  logic [1:0]    edge0, edge1, edge2;
  logic [3:0]    nb_sum;

  // Handshake
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign s2_go     = s2_v_r && (!out_valid_r || out_ready);
  assign s1_go     = s1_v_r && (!s2_v_r || s2_go);
  assign in_ready  = !s1_v_r || s1_go;
  assign in_fire   = in_valid && in_ready;

  // Raster position of the next cell
  assign col_wrap = (32'(col_r) + 32'd1) >= 32'(grid_w_r);
  assign row_wrap = (32'(row_r) + 32'd1) >= 32'(grid_h_r);
  assign col_nxt  = col_wrap ? '0 : col_r + CW'(1);
  assign row_nxt  = !col_wrap ? row_r : (row_wrap ? '0 : row_r + RW'(1));
  assign fill_nxt = (32'(col_r) + 32'd1 > 32'(fill_r)) ? HW'(32'(col_r) + 32'd1) : fill_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_w_r <= WIDTH_RST;
      grid_h_r <= HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      fill_r   <= '0;
    end else if (cfg_fire) begin
      if (cfg_index == REG_GRID_WIDTH) begin
        grid_w_r <= clamp_size(cfg_data, MAX_WIDTH);
        col_r    <= '0;
        row_r    <= '0;
      end else if (cfg_index == REG_GRID_HEIGHT) begin
        grid_h_r <= clamp_size(cfg_data, MAX_HEIGHT);
        col_r    <= '0;
        row_r    <= '0;
      end
    end else if (in_fire) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Line stores: bit 1 upper row, bit 0 middle row
  lrs_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_lines (
    .clk  (clk),
    .we   (s1_go),
    .waddr(s1_addr_r),
    .wdata({mid_bit, s1_bit_r}),
    .re   (in_fire),
    .raddr(col_r),
    .rdata(rdata)
  );

  // Stage 1: line store read in flight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_go) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_bit_r   <= in_cell_in;
      s1_addr_r  <= col_r;
      s1_fresh_r <= 32'(col_r) >= 32'(fill_r);
      s1_emit_r  <= (32'(row_r) >= 32'd2) && (32'(col_r) >= 32'd2);
      s1_last_r  <= row_wrap && col_wrap;
    end
  end

  // Unwritten entries read as dead cells
  assign top_bit = !s1_fresh_r && rdata[1];
  assign mid_bit = !s1_fresh_r && rdata[0];
  assign new_col = {s1_bit_r, mid_bit, top_bit};

  // Window: chain of three column cells, newest on the right
  lrs_cell u_cell2 (
    .clk(clk), .rst_n(rst_n), .shift_en(s1_go),
    .col_in(new_col), .col_out(col2), .edge_live(edge2)
  );
  lrs_cell u_cell1 (
    .clk(clk), .rst_n(rst_n), .shift_en(s1_go),
    .col_in(col2), .col_out(col1), .edge_live(edge1)
  );
  lrs_cell u_cell0 (
    .clk(clk), .rst_n(rst_n), .shift_en(s1_go),
    .col_in(col1), .col_out(col0), .edge_live(edge0)
  );

  // Stage 2: window holds the neighborhood
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s1_go) begin
      s2_v_r <= 1'b1;
    end else if (s2_go) begin
      s2_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_emit_r <= s1_emit_r;
      s2_last_r <= s1_last_r;
    end
  end

  // Count live neighbors, centre excluded
  assign nb_sum = 4'(edge0) + 4'(edge1) + 4'(edge2) + 4'(col0[1]) + 4'(col2[1]);

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_go) begin
      out_valid_r <= s2_emit_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_cell_r <= life_next(col1[1], nb_sum);
      out_last_r <= s2_last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_cell_out  = out_cell_r;
  assign out_last_cell = out_last_r;

endmodule

/* sv/lrs_checker.sv */
module lrs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_cell_out,
  input logic out_last_cell,
  input logic cfg_valid,
  input logic cfg_ready
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cell_out) && $stable(out_last_cell))
    else $error("result changed while stalled");

  // Reset empties the output
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result present after reset");

  // No pending result means the pipe can take a cell
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // Configuration writes are never stalled
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

  // A cell taken with a free output leaves the input side ready
  a_in_flow: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |=> in_ready || out_valid)
    else $error("input stalled without a pending result");

endmodule

bind life_rule_stencil_3x3_core lrs_checker u_lrs_checker (.*);

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;
  import lrs_pkg::*;

  localparam int GRID_MAX      = 1024;
  localparam int RANDOM_ITEMS  = 1200;
  localparam int WIDE_CELLS    = 64;
  localparam int TALL_CELLS    = 300;
  localparam int SETTLE        = 8;
  localparam int DRAIN_LIMIT   = 200000;
  localparam int PRINT_LIMIT   = 30;

  // Indexes outside the register list; writes there are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic alive;
    logic frame_end;
  } life_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_cell_in = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_cell_out;
  logic                  out_last_cell;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Stimulus and expectation stores
  logic         cell_feed_q[$];
  life_result_t next_gen_q[$];

  int send_idle = 12;
  int recv_idle = 83;
  int cells_queued = 0;
  int cells_taken = 0;
  int results_checked = 0;
  int cfg_writes = 0;
  int err_count = 0;
  int random_items = 0;
  int cur_w = GRID_RST;
  int cur_h = GRID_RST;

  // Predictor state
  logic        upper_row  [0:GRID_MAX-1];
  logic        middle_row [0:GRID_MAX-1];
  logic [8:0]  win;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned width_m;
  int unsigned height_m;

  life_rule_stencil_3x3_core #(
    .MAX_WIDTH (GRID_MAX),
    .MAX_HEIGHT(GRID_MAX)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_cell_in   (in_cell_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_cell_out (out_cell_out),
    .out_last_cell(out_last_cell),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    if (err_count < PRINT_LIMIT) begin
      $display("MISMATCH @%0t: %s", $time, msg);
    end
    err_count++;
  endtask

  // Saturate a raw grid side to [3, GRID_MAX]
  function automatic int unsigned grid_clamp(input logic [CFG_DATA_W-1:0] v);
    int unsigned res;
    res = 32'(v);
    if (res < 3) begin
      res = 3;
    end else if (res > GRID_MAX) begin
      res = GRID_MAX;
    end
    return res;
  endfunction

  // Advance the stencil by one cell and queue the next-generation result
  task automatic step_life(input logic cell_bit);
    logic         top;
    logic         mid;
    logic         centre;
    int           live;
    life_result_t r;
    top = upper_row[col_pos];
    mid = middle_row[col_pos];
    upper_row[col_pos]  = mid;
    middle_row[col_pos] = cell_bit;
    win = {cell_bit, mid, top, win[8:3]};
    if (row_pos >= 2 && col_pos >= 2) begin
      centre = win[4];
      live = $countones(win) - centre;
      r.alive = (live == BIRTH_CNT) || (centre && live == KEEP_CNT);
      r.frame_end = (row_pos == height_m - 1) && (col_pos == width_m - 1);
      next_gen_q.push_back(r);
    end
    col_pos++;
    if (col_pos >= width_m) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= height_m) begin
        row_pos = 0;
      end
    end
  endtask

  // Driver: present the next pending cell, holding it until accepted
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (cell_feed_q.size() != 0 && $urandom_range(99) >= send_idle) begin
        in_valid   <= 1'b1;
        in_cell_in <= cell_feed_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Monitor: track config and input transactions, check each result
  always @(posedge clk) begin
    life_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < GRID_MAX; k++) begin
        upper_row[k]  = 1'b0;
        middle_row[k] = 1'b0;
      end
      win      = '0;
      col_pos  = 0;
      row_pos  = 0;
      width_m  = GRID_RST;
      height_m = GRID_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cfg_writes++;
        case (cfg_index)
          REG_GRID_WIDTH: begin
            width_m = grid_clamp(cfg_data);
            col_pos = 0;
            row_pos = 0;
          end
          REG_GRID_HEIGHT: begin
            height_m = grid_clamp(cfg_data);
            col_pos = 0;
            row_pos = 0;
          end
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (next_gen_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = next_gen_q.pop_front();
          if (out_cell_out !== want.alive) begin
            report_mismatch($sformatf("result %0d cell_out: got %b, want %b",
                                      results_checked, out_cell_out, want.alive));
          end
          if (out_last_cell !== want.frame_end) begin
            report_mismatch($sformatf("result %0d last_cell: got %b, want %b",
                                      results_checked, out_last_cell, want.frame_end));
          end
        end
        results_checked++;
      end
      if (in_valid && in_ready) begin
        step_life(in_cell_in);
        cells_taken++;
      end
    end
  end

  task automatic add_cell(input logic b);
    cell_feed_q.push_back(b);
    cells_queued++;
  endtask

  task automatic queue_cells(input int count, input int density);
    repeat (count) add_cell($urandom_range(99) < density);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GRID_WIDTH) begin
      cur_w = grid_clamp(data);
    end else if (idx == REG_GRID_HEIGHT) begin
      cur_h = grid_clamp(data);
    end
  endtask

  // Wait until every queued cell is taken and every result checked
  task automatic drain();
    int waited;
    waited = 0;
    while ((cells_taken != cells_queued || next_gen_q.size() != 0) && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic random_phase();
    logic [CFG_DATA_W-1:0] raw_w;
    logic [CFG_DATA_W-1:0] raw_h;
    int                    sel;
    int                    count;
    int                    density;
    raw_w = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(2))
                                     : CFG_DATA_W'($urandom_range(3, 12));
    raw_h = ($urandom_range(7) == 0) ? CFG_DATA_W'($urandom_range(2))
                                     : CFG_DATA_W'($urandom_range(3, 10));
    if ($urandom_range(5) == 0) begin
      write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3, CFG_DATA_W'($urandom));
    end
    sel = $urandom_range(3);
    if (sel != 1) write_reg(REG_GRID_WIDTH, raw_w);
    if (sel != 0) write_reg(REG_GRID_HEIGHT, raw_h);
    // Mostly whole frames; now and then stop mid-frame
    if ($urandom_range(4) == 0) begin
      count = $urandom_range(1, 2 * cur_w * cur_h);
    end else begin
      count = $urandom_range(1, 3) * cur_w * cur_h;
    end
    case ($urandom_range(5))
      0:       density = 5;
      1:       density = 90;
      default: density = $urandom_range(20, 60);
    endcase
    queue_cells(count, density);
    random_items += count;
    drain();
  endtask

  initial begin
    logic [8:0] birth;
    birth = 9'b001000011;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset sizes: a few cells in row 0, then restart the frame mid-row
    add_cell(1'b1);
    add_cell(1'b0);
    add_cell(1'b1);
    add_cell(1'b1);
    drain();
    write_reg(REG_GRID_WIDTH, 11'd0);
    write_reg(REG_GRID_HEIGHT, 11'd2);
    write_reg(REG_SPARE_2, 11'h7FF);
    write_reg(REG_SPARE_3, 11'd0);

    // Smallest frame: all alive (overcrowded), then a birth pattern
    repeat (9) add_cell(1'b1);
    for (int k = 0; k < 9; k++) add_cell(birth[k]);
    drain();

    // Random frames over three back-pressure regimes
    while (random_items < RANDOM_ITEMS) begin
      if (random_items < RANDOM_ITEMS / 3) begin
        send_idle = 12;
        recv_idle = 83;
      end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
        send_idle = 83;
        recv_idle = 12;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      random_phase();
    end

    // Widest frame, sizes saturated: the start of its first row
    write_reg(REG_GRID_WIDTH, 11'h7FF);
    write_reg(REG_GRID_HEIGHT, 11'd0);
    queue_cells(WIDE_CELLS, 40);
    drain();
    // Tallest frame: narrow rows down the upper part of the frame
    write_reg(REG_GRID_WIDTH, 11'd1);
    write_reg(REG_GRID_HEIGHT, 11'h7FF);
    queue_cells(TALL_CELLS, 50);
    drain();

    if (next_gen_q.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived", next_gen_q.size()));
    end
    $display("Streamed %0d cells through %0d register writes, frames from 3x3 up to 1024 a side",
             cells_taken, cfg_writes);
    $display("Checked %0d next-generation results, %0d mismatches", results_checked, err_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("Timeout with %0d cells taken of %0d", cells_taken, cells_queued);
    $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
sv/lrs_pkg.sv
sv/lrs_ram.sv
sv/lrs_cell.sv
sv/life_rule_stencil_3x3_core.sv
sv/lrs_checker.sv
bench/tb.sv
